// ----- src/bscp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bscp_pkg: shared types and constants
// Payload structs, register codes and the bearing arctangent table for the
// billboard sprite column projection block.
// ----------------------------------------------------------------------------
package bscp_pkg;

  typedef struct packed {
    logic [23:0] player_x;
    logic [23:0] player_y;
    logic [15:0] player_angle;
    logic [23:0] sprite_x;
    logic [23:0] sprite_y;
    logic        sprite_dead;
    logic [3:0]  frame_index;
    logic [11:0] column;
    logic [23:0] wall_distance;
  } bscp_in_t;

  typedef struct packed {
    logic               visible;
    logic        [24:0] sprite_distance;
    logic signed [23:0] draw_top;
    logic signed [23:0] draw_bottom;
    logic        [9:0]  texture_column;
  } bscp_out_t;

  typedef struct packed {
    logic [15:0] fov_angle;
    logic [11:0] view_cols;
    logic [11:0] view_rows;
    logic [23:0] height_scale;
  } bscp_cfg_t;

  // front-to-back queue entry
  typedef struct packed {
    logic        [48:0] dist_sq;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [15:0] player_angle;
    logic               sprite_dead;
    logic        [3:0]  frame_index;
    logic        [11:0] column;
    logic        [23:0] wall_distance;
  } bscp_work_t;

  typedef enum logic [1:0] {
    CFG_FOV_ANGLE    = 2'd0,
    CFG_VIEW_COLS    = 2'd1,
    CFG_VIEW_ROWS    = 2'd2,
    CFG_HEIGHT_SCALE = 2'd3
  } bscp_cfg_idx_e;

  localparam logic [15:0] FOV_RESET    = 16'd10923;
  localparam logic [11:0] WIDTH_RESET  = 12'd800;
  localparam logic [11:0] HEIGHT_RESET = 12'd600;
  localparam logic [23:0] SCALE_RESET  = 24'd17728;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 25;
  localparam int unsigned CDIV_STEPS   = 30;
  localparam int unsigned SIZE_BITS    = 23;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // atan(2^-i) in 2^24 units per turn
  function automatic logic [23:0] atan_lut(input logic [3:0] idx);
    logic [23:0] r;
    case (idx)
      4'd0:    r = 24'd2097152;
      4'd1:    r = 24'd1238021;
      4'd2:    r = 24'd654136;
      4'd3:    r = 24'd332050;
      4'd4:    r = 24'd166669;
      4'd5:    r = 24'd83416;
      4'd6:    r = 24'd41718;
      4'd7:    r = 24'd20860;
      4'd8:    r = 24'd10430;
      4'd9:    r = 24'd5215;
      4'd10:   r = 24'd2608;
      4'd11:   r = 24'd1304;
      4'd12:   r = 24'd652;
      4'd13:   r = 24'd326;
      4'd14:   r = 24'd163;
      4'd15:   r = 24'd81;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/bscp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bscp_front: input stage
// Accepts transactions, forms the player-to-sprite offset and its squared
// length, and pushes work entries into the queue.
// ----------------------------------------------------------------------------
module bscp_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bscp_pkg::bscp_in_t   in_data_i,
  output logic                 push_valid_o,
  input  wire                  push_ready_i,
  output bscp_pkg::bscp_work_t push_data_o
);
  import bscp_pkg::*;

  logic               en;
  logic               f1_vld_q, f2_vld_q;
  logic signed [24:0] dx_d, dy_d;
  logic signed [49:0] dxsq_full, dysq_full;
  bscp_work_t         f1_q, f2_q;
  logic        [47:0] dxsq_q, dysq_q;

  assign en         = !f2_vld_q || push_ready_i;
  assign in_ready_o = en;

  assign dx_d = $signed({1'b0, in_data_i.sprite_x}) - $signed({1'b0, in_data_i.player_x});
  assign dy_d = $signed({1'b0, in_data_i.sprite_y}) - $signed({1'b0, in_data_i.player_y});

  assign dxsq_full = f1_q.dx * f1_q.dx;
  assign dysq_full = f1_q.dy * f1_q.dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q.dist_sq       <= '0;
      f1_q.dx            <= dx_d;
      f1_q.dy            <= dy_d;
      f1_q.player_angle  <= in_data_i.player_angle;
      f1_q.sprite_dead   <= in_data_i.sprite_dead;
      f1_q.frame_index   <= in_data_i.frame_index;
      f1_q.column        <= in_data_i.column;
      f1_q.wall_distance <= in_data_i.wall_distance;
      f2_q               <= f1_q;
      dxsq_q             <= dxsq_full[47:0];
      dysq_q             <= dysq_full[47:0];
    end
  end

  always_comb begin
    push_data_o         = f2_q;
    push_data_o.dist_sq = {1'b0, dxsq_q} + {1'b0, dysq_q};
  end

  assign push_valid_o = f2_vld_q;

endmodule
`default_nettype wire

// ----- src/bscp_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bscp_fifo: work queue
// Short queue that decouples the input stage from the projection pipeline.
// ----------------------------------------------------------------------------
module bscp_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  bscp_pkg::bscp_work_t push_data_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output bscp_pkg::bscp_work_t pop_data_o
);
  import bscp_pkg::*;

  bscp_work_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign push_ready_o = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ----- src/bscp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bscp_back: projection pipeline
// Square root and CORDIC bearing, then centre and size dividers, then span
// test and texture column divider. Whole pipeline stalls on the output.
// ----------------------------------------------------------------------------
module bscp_back #(
  parameter int unsigned TEXTURE_WIDTH = 64,
  parameter int unsigned FRAME_COUNT   = 16,
  parameter int unsigned FRAC_BITS     = 12
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bscp_pkg::bscp_cfg_t  cfg_i,
  input  wire                  pop_valid_i,
  output logic                 pop_ready_o,
  input  bscp_pkg::bscp_work_t pop_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output bscp_pkg::bscp_out_t  out_data_o
);
  import bscp_pkg::*;

  localparam int unsigned NUMW = 24 + FRAC_BITS;
  localparam int unsigned QB   = $clog2(TEXTURE_WIDTH);
  localparam int unsigned TWW  = $clog2(TEXTURE_WIDTH + 1);
  localparam int unsigned ONW  = 25 + TWW;

  typedef struct packed {
    logic [15:0] pang;
    logic        dead;
    logic [3:0]  frame;
    logic [11:0] col;
    logic [23:0] wall;
  } tag_t;

  typedef struct packed {
    tag_t               tag;
    logic        [49:0] vp;
    logic        [26:0] rem;
    logic        [24:0] root;
    logic signed [27:0] cx;
    logic signed [27:0] cy;
    logic        [23:0] cz;
    logic               zero;
  } geo_t;

  typedef struct packed {
    tag_t                   tag;
    logic [24:0]            sdist;
    logic                   neg;
    logic [29:0]            cmag;
    logic [16:0]            dc;
    logic [16:0]            crem;
    logic [29:0]            cq;
    logic [SIZE_BITS-1:0]   snum;
    logic [24:0]            srem;
    logic [SIZE_BITS-1:0]   sq;
    logic                   sat;
  } div_t;

  typedef struct packed {
    tag_t                 tag;
    logic [24:0]          sdist;
    logic signed [30:0]   centre;
    logic [SIZE_BITS-1:0] size;
  } prj_t;

  typedef struct packed {
    logic               vis;
    logic [3:0]         frame;
    logic [24:0]        sdist;
    logic signed [23:0] top;
    logic signed [23:0] bottom;
    logic [QB-1:0]      olow;
    logic [24:0]        orem;
    logic [23:0]        od;
    logic [QB-1:0]      oq;
  } off_t;

  function automatic logic [3:0] frame_mod(input logic [3:0] f);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (f == 4'(i)) r = 4'(i % FRAME_COUNT);
    end
    return r;
  endfunction

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_ready_o = en;

  // --------------------------------------------------------------------------
  // square root and bearing
  logic [SQRT_STEPS-1:0] gv_q;
  geo_t                  geo_q [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_geo
    geo_t        gi, go;
    logic        vin;
    logic [28:0] t, trial;

    if (s == 0) begin : g_init
      logic flip;
      assign flip = pop_data_i.dx[24];
      assign vin  = pop_valid_i;
      always_comb begin
        gi.tag.pang  = pop_data_i.player_angle;
        gi.tag.dead  = pop_data_i.sprite_dead;
        gi.tag.frame = pop_data_i.frame_index;
        gi.tag.col   = pop_data_i.column;
        gi.tag.wall  = pop_data_i.wall_distance;
        gi.vp        = {1'b0, pop_data_i.dist_sq};
        gi.rem       = '0;
        gi.root      = '0;
        gi.cx        = $signed({{3{pop_data_i.dx[24]}}, pop_data_i.dx});
        gi.cy        = $signed({{3{pop_data_i.dy[24]}}, pop_data_i.dy});
        if (flip) begin
          gi.cx = -gi.cx;
          gi.cy = -gi.cy;
        end
        gi.cz   = flip ? 24'h800000 : 24'h000000;
        gi.zero = pop_data_i.dist_sq == '0;
      end
    end else begin : g_chain
      assign vin = gv_q[s-1];
      assign gi  = geo_q[s-1];
    end

    assign t     = {gi.rem, gi.vp[49-2*s -: 2]};
    assign trial = {2'b00, gi.root, 2'b01};

    always_comb begin
      go = gi;
      if (t >= trial) begin
        go.rem  = 27'(t - trial);
        go.root = {gi.root[23:0], 1'b1};
      end else begin
        go.rem  = t[26:0];
        go.root = {gi.root[23:0], 1'b0};
      end
      if (s < CORDIC_STEPS) begin
        if (gi.cy > 28'sd0) begin
          go.cx = gi.cx + (gi.cy >>> s);
          go.cy = gi.cy - (gi.cx >>> s);
          go.cz = gi.cz + atan_lut(4'(s));
        end else begin
          go.cx = gi.cx - (gi.cy >>> s);
          go.cy = gi.cy + (gi.cx >>> s);
          go.cz = gi.cz - atan_lut(4'(s));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) gv_q[s] <= 1'b0;
      else if (en) gv_q[s] <= vin;
    end

    always_ff @(posedge clk_i) begin
      if (en) geo_q[s] <= go;
    end
  end

  // --------------------------------------------------------------------------
  // bearing difference, centre numerator, size overflow check
  geo_t               gl;
  logic [24:0]        rnd;
  logic [15:0]        bear, diff, fov;
  logic signed [17:0] csum;
  logic signed [30:0] cprod;
  logic [NUMW-1:0]    snum_full;
  logic [NUMW-24:0]   srem0;
  div_t               dm_d, dm_q;
  logic               mv_q;

  assign gl        = geo_q[SQRT_STEPS-1];
  assign rnd       = {1'b0, gl.cz} + 25'd128;
  assign bear      = gl.zero ? 16'd0 : rnd[23:8];
  assign diff      = bear - gl.tag.pang;
  assign fov       = (cfg_i.fov_angle == '0) ? 16'd1 : cfg_i.fov_angle;
  assign csum      = $signed({2'b00, fov}) + $signed({diff[15], diff, 1'b0});
  assign cprod     = csum * $signed({1'b0, cfg_i.view_cols});
  assign snum_full = {cfg_i.height_scale, {FRAC_BITS{1'b0}}};
  assign srem0     = snum_full[NUMW-1:SIZE_BITS];

  always_comb begin
    dm_d.tag   = gl.tag;
    dm_d.sdist = gl.root;
    dm_d.neg   = cprod[30];
    dm_d.cmag  = cprod[30] ? 30'(-cprod) : cprod[29:0];
    dm_d.dc    = {fov, 1'b0};
    dm_d.crem  = '0;
    dm_d.cq    = '0;
    dm_d.snum  = snum_full[SIZE_BITS-1:0];
    dm_d.srem  = 25'(srem0);
    dm_d.sq    = '0;
    dm_d.sat   = {gl.root, {SIZE_BITS{1'b0}}} <= 48'(snum_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q <= 1'b0;
    else if (en) mv_q <= gv_q[SQRT_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) dm_q <= dm_d;
  end

  // --------------------------------------------------------------------------
  // centre and size dividers, one quotient bit per stage
  logic [CDIV_STEPS-1:0] dv_q;
  div_t                  div_q [CDIV_STEPS];

  for (genvar s = 0; s < CDIV_STEPS; s++) begin : g_div
    div_t        di, dd;
    logic        vin;
    logic [17:0] ct;
    logic [25:0] st;

    if (s == 0) begin : g_first
      assign vin = mv_q;
      assign di  = dm_q;
    end else begin : g_chain
      assign vin = dv_q[s-1];
      assign di  = div_q[s-1];
    end

    assign ct = {di.crem, di.cmag[CDIV_STEPS-1-s]};
    if (s < SIZE_BITS) begin : g_st
      assign st = {di.srem, di.snum[SIZE_BITS-1-s]};
    end else begin : g_st_idle
      assign st = '0;
    end

    always_comb begin
      dd = di;
      if (ct >= {1'b0, di.dc}) begin
        dd.crem = 17'(ct - {1'b0, di.dc});
        dd.cq   = {di.cq[28:0], 1'b1};
      end else begin
        dd.crem = ct[16:0];
        dd.cq   = {di.cq[28:0], 1'b0};
      end
      if (s < SIZE_BITS) begin
        if (st >= {1'b0, di.sdist}) begin
          dd.srem = 25'(st - {1'b0, di.sdist});
          dd.sq   = {di.sq[SIZE_BITS-2:0], 1'b1};
        end else begin
          dd.srem = st[24:0];
          dd.sq   = {di.sq[SIZE_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[s] <= 1'b0;
      else if (en) dv_q[s] <= vin;
    end

    always_ff @(posedge clk_i) begin
      if (en) div_q[s] <= dd;
    end
  end

  // --------------------------------------------------------------------------
  // signed centre, saturated size
  div_t dl;
  prj_t pr_d, pr_q;
  logic pv_q;

  assign dl = div_q[CDIV_STEPS-1];

  always_comb begin
    pr_d.tag    = dl.tag;
    pr_d.sdist  = dl.sdist;
    pr_d.centre = dl.neg ? -$signed({1'b0, dl.cq}) : $signed({1'b0, dl.cq});
    pr_d.size   = dl.sat ? SIZE_MAX : dl.sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (en) pv_q <= dv_q[CDIV_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) pr_q <= pr_d;
  end

  // --------------------------------------------------------------------------
  // rows, span test, texture offset numerator
  logic signed [33:0] c2, lo2, hi2, span, szx;
  logic signed [24:0] tdiff, top, bottom;
  logic [ONW-1:0]     onum, onum_sh;
  off_t               of_d;
  logic               ov0_q;

  assign szx    = $signed({11'b0, pr_q.size});
  assign c2     = $signed({21'b0, pr_q.tag.col, 1'b0});
  assign lo2    = $signed({{2{pr_q.centre[30]}}, pr_q.centre, 1'b0}) - szx;
  assign hi2    = $signed({{2{pr_q.centre[30]}}, pr_q.centre, 1'b0}) + szx;
  assign span   = c2 - lo2;
  assign tdiff  = $signed({13'b0, cfg_i.view_rows}) - $signed({2'b00, pr_q.size});
  assign top    = tdiff >>> 1;
  assign bottom = top + $signed({2'b00, pr_q.size});
  assign onum   = ONW'(span[24:0]) * ONW'(TEXTURE_WIDTH);
  assign onum_sh = onum >> QB;

  always_comb begin
    of_d.vis    = !pr_q.tag.dead && (c2 >= lo2) && (c2 < hi2) &&
                  (pr_q.sdist < {1'b0, pr_q.tag.wall});
    of_d.frame  = pr_q.tag.frame;
    of_d.sdist  = pr_q.sdist;
    of_d.top    = top[23:0];
    of_d.bottom = bottom[23:0];
    of_d.olow   = onum[QB-1:0];
    of_d.orem   = onum_sh[24:0];
    of_d.od     = {pr_q.size, 1'b0};
    of_d.oq     = '0;
  end

  off_t off_q0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov0_q <= 1'b0;
    else if (en) ov0_q <= pv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) off_q0 <= of_d;
  end

  // --------------------------------------------------------------------------
  // texture offset divider
  logic [QB-1:0] ov_q;
  off_t          off_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_off
    off_t        oi, od;
    logic        vin;
    logic [25:0] t;

    if (s == 0) begin : g_first
      assign vin = ov0_q;
      assign oi  = off_q0;
    end else begin : g_chain
      assign vin = ov_q[s-1];
      assign oi  = off_q[s-1];
    end

    assign t = {oi.orem, oi.olow[QB-1-s]};

    always_comb begin
      od = oi;
      if (t >= {2'b00, oi.od}) begin
        od.orem = 25'(t - {2'b00, oi.od});
        od.oq   = QB'({oi.oq, 1'b1});
      end else begin
        od.orem = t[24:0];
        od.oq   = QB'({oi.oq, 1'b0});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ov_q[s] <= 1'b0;
      else if (en) ov_q[s] <= vin;
    end

    always_ff @(posedge clk_i) begin
      if (en) off_q[s] <= od;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  off_t        ol;
  logic [17:0] tex_sum;
  bscp_out_t   out_q;

  assign ol      = off_q[QB-1];
  assign tex_sum = 18'(frame_mod(ol.frame)) * 18'(TEXTURE_WIDTH) + 18'(ol.oq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= ov_q[QB-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.visible         <= ol.vis;
      out_q.sprite_distance <= ol.sdist;
      out_q.draw_top        <= ol.top;
      out_q.draw_bottom     <= ol.bottom;
      out_q.texture_column  <= ol.vis ? tex_sum[9:0] : 10'd0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- src/billboard_sprite_column_projection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// billboard_sprite_column_projection: sprite-versus-column billboard test
// Top level: configuration registers, input stage, work queue, projection
// pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per sprite/column pair (valid/ready).
//   out_* : one transaction per input: visibility, distance, top and bottom
//           rows, sprite-sheet column (valid/ready).
//   cfg_* : write-only registers (fov, screen width/height, height scale),
//           written at any edge with cfg_we_i high; change them only while
//           the block is drained.
// Throughput: one transaction per cycle while the output is taken.
// Path from input acceptance to out valid: 2 input-stage registers,
//   one queue slot, 25 square root / CORDIC stages, one setup stage,
//   30 divider stages for the centre column (size divider shares the
//   first 23), two row/span stages, one stage per texture offset
//   quotient bit, output register.
// Stall: a held output freezes the projection pipeline; the 4-entry queue
//   and input stage keep taking transactions until the queue fills.
// Reset: clears all valid bits and queue pointers, loads register defaults.
// ----------------------------------------------------------------------------
module billboard_sprite_column_projection #(
  parameter int unsigned TEXTURE_WIDTH = 64,
  parameter int unsigned FRAME_COUNT   = 16,
  parameter int unsigned FRAC_BITS     = 12
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_idx_i,
  input  wire  [23:0]         cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bscp_pkg::bscp_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output bscp_pkg::bscp_out_t out_data_o
);
  import bscp_pkg::*;

  bscp_cfg_t  cfg_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  bscp_work_t push_data, pop_data;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fov_angle    <= FOV_RESET;
      cfg_q.view_cols    <= WIDTH_RESET;
      cfg_q.view_rows    <= HEIGHT_RESET;
      cfg_q.height_scale <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (bscp_cfg_idx_e'(cfg_idx_i))
        CFG_FOV_ANGLE:    cfg_q.fov_angle    <= cfg_data_i[15:0];
        CFG_VIEW_COLS:    cfg_q.view_cols    <= cfg_data_i[11:0];
        CFG_VIEW_ROWS:    cfg_q.view_rows    <= cfg_data_i[11:0];
        CFG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset and squared distance
  bscp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decoupling queue
  bscp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // distance, bearing, projection, texture column
  bscp_back #(
    .TEXTURE_WIDTH (TEXTURE_WIDTH),
    .FRAME_COUNT   (FRAME_COUNT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
